FILE: src/pdfsu_pkg.sv
// ----------------------------------------------------------------------------
// pdfsu_pkg
// Shared types, constants and helpers of the literal string unescape block.
// ----------------------------------------------------------------------------
package pdfsu_pkg;

   localparam int BYTE_W                   = 8;
   localparam int CFG_W                    = 15;
   localparam int PAREN_DEPTH_BITS_DEFAULT = 16;
   localparam int LENGTH_BITS_DEFAULT      = 15;
   localparam int QUEUE_DEPTH              = 4;

   localparam logic [CFG_W-1:0] MAX_LEN_RESET = 15'h7FFF;

   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
   localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
   localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
   localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
   localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
   localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
   localparam logic [BYTE_W-1:0] CH_F      = 8'h66;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              string_end;
      logic              closed_by_paren;
   } rsp_type;

   // up to two decoded bytes and an end marker for one input word
   typedef struct packed {
      logic [BYTE_W-1:0] data0;
      logic              has0;
      logic [BYTE_W-1:0] data1;
      logic              has1;
      logic              fin;
      logic              by_paren;
   } cmd_type;

   typedef struct packed {
      logic idle;
   } front_stat_type;

   typedef enum logic [4:0] {
      ESC_NORMAL = 5'b00001,
      ESC_BSLASH = 5'b00010,
      ESC_OCT1   = 5'b00100,
      ESC_OCT2   = 5'b01000,
      ESC_CR     = 5'b10000
   } esc_type;

   function automatic logic is_octal(input logic [BYTE_W-1:0] c);
      return c[7:3] == 5'b00110;
   endfunction

   function automatic logic [BYTE_W-1:0] escape_map(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      case (c)
         CH_N:    r = CH_LF;
         CH_R:    r = CH_CR;
         CH_T:    r = CH_TAB;
         CH_B:    r = CH_BS;
         CH_F:    r = CH_FF;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

FILE: src/pdf_literal_string_unescape_top.sv
// ----------------------------------------------------------------------------
// pdf_literal_string_unescape_top
// Decoder for the body of a PDF literal string, one raw byte per input word.
// ----------------------------------------------------------------------------
// The block takes one raw word per cycle whenever its four-entry command queue
// has room. Each input word yields zero to three result words (up to two
// decoded bytes and an end marker); the output stage sends one result word per
// cycle from a register while the receiver takes them, so the sustained rate
// is one input word per cycle as long as most input words give at most one
// result, and the output port bounds it otherwise. The first result word of
// an input word passes through the command queue and then the output
// register. The length limit register is written through the csr port, which
// never stalls, and applies from the next input word on.
module pdf_literal_string_unescape_top #(
   parameter int PAREN_DEPTH_BITS = pdfsu_pkg::PAREN_DEPTH_BITS_DEFAULT,
   parameter int LENGTH_BITS      = pdfsu_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pdfsu_pkg::req_type          req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pdfsu_pkg::rsp_type          rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pdfsu_pkg::CFG_W-1:0] csr_data
);
   import pdfsu_pkg::*;

   logic           q_full, q_empty, q_push, q_pop;
   cmd_type        q_in, q_head;
   front_stat_type front_stat;

   assign csr_ready = 1'b1;

   pdfsu_front #(
      .PAREN_DEPTH_BITS (PAREN_DEPTH_BITS),
      .LENGTH_BITS      (LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .cmd_push  (q_push),
      .cmd_data  (q_in),
      .stat      (front_stat)
   );

   pdfsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   pdfsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("command pushed into full queue");

   a_clear_after_end : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.end_of_buffer |=> front_stat.idle)
      else $error("string state not cleared after buffer end");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from empty queue");

   a_quiet_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word shown right after reset");

endmodule

FILE: src/pdfsu_front.sv
// ----------------------------------------------------------------------------
// pdfsu_front
// Escape, nesting and length tracking; an input word makes at most one command.
// ----------------------------------------------------------------------------
module pdfsu_front #(
   parameter int PAREN_DEPTH_BITS = pdfsu_pkg::PAREN_DEPTH_BITS_DEFAULT,
   parameter int LENGTH_BITS      = pdfsu_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  pdfsu_pkg::req_type         req_data,
   input  logic                       csr_valid,
   input  logic [pdfsu_pkg::CFG_W-1:0] csr_data,
   input  logic                       q_full,
   output logic                       cmd_push,
   output pdfsu_pkg::cmd_type         cmd_data,
   output pdfsu_pkg::front_stat_type  stat
);
   import pdfsu_pkg::*;

   localparam int CW = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
   localparam logic [CW-1:0] COUNT_MAX = CW'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [PAREN_DEPTH_BITS-1:0] DEPTH_MAX = '1;

   logic [CFG_W-1:0]            max_len_ff;
   esc_type                     mode_ff, mode_in;
   logic [PAREN_DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [BYTE_W-1:0]           code_ff, code_in;
   logic [LENGTH_BITS-1:0]      count_ff;

   logic [BYTE_W-1:0] c;
   logic [BYTE_W-1:0] code_shift;
   logic [BYTE_W-1:0] b0;
   logic              e0, e1, v0, v1, run_norm, closed, fin, accept;
   logic [CW-1:0]     lim, cnt0, cnt1, cnt2;

   assign accept    = req_valid && !q_full;
   assign req_ready = !q_full;
   assign c         = req_data.in_byte;
   assign code_shift = {code_ff[4:0], c[2:0]};

   always_comb begin
      mode_in  = ESC_NORMAL;
      code_in  = code_ff;
      e0       = 1'b0;
      b0       = code_ff;
      run_norm = 1'b0;
      unique case (mode_ff) inside
         ESC_BSLASH: begin
            if (is_octal(c)) begin
               code_in = {5'b0, c[2:0]};
               mode_in = ESC_OCT1;
            end else if (c == CH_CR) begin
               mode_in = ESC_CR;
            end else begin
               e0 = (c != CH_LF);
               b0 = escape_map(c);
            end
         end
         ESC_OCT1, ESC_OCT2: begin
            if (is_octal(c)) begin
               code_in = code_shift;
               if (mode_ff == ESC_OCT2) begin
                  e0 = 1'b1;
                  b0 = code_shift;
               end else begin
                  mode_in = ESC_OCT2;
               end
            end else begin
               e0       = 1'b1;
               run_norm = 1'b1;
            end
         end
         ESC_CR:  run_norm = (c != CH_LF);
         default: run_norm = 1'b1;
      endcase

      depth_in = depth_ff;
      closed   = 1'b0;
      e1       = 1'b0;
      if (run_norm) begin
         if (c == CH_RPAREN) begin
            if (depth_ff == '0) begin
               closed = 1'b1;
            end else begin
               depth_in = depth_ff - PAREN_DEPTH_BITS'(1);
               e1       = 1'b1;
            end
         end else if (c == CH_LPAREN) begin
            if (depth_ff != DEPTH_MAX) depth_in = depth_ff + PAREN_DEPTH_BITS'(1);
            e1 = 1'b1;
         end else if (c == CH_BSLASH) begin
            mode_in = ESC_BSLASH;
         end else begin
            e1 = 1'b1;
         end
      end

      lim  = (CW'(max_len_ff) < COUNT_MAX) ? CW'(max_len_ff) : COUNT_MAX;
      cnt0 = CW'(count_ff);
      v0   = e0 && (cnt0 < lim);
      cnt1 = cnt0 + CW'(v0);
      v1   = e1 && (cnt1 < lim);
      cnt2 = cnt1 + CW'(v1);
      fin  = closed || req_data.end_of_buffer;
   end

   assign cmd_data.data0    = b0;
   assign cmd_data.has0     = v0;
   assign cmd_data.data1    = c;
   assign cmd_data.has1     = v1;
   assign cmd_data.fin      = fin;
   assign cmd_data.by_paren = closed;
   assign cmd_push          = accept && (v0 || v1 || fin);

   assign stat.idle = (mode_ff == ESC_NORMAL) && (depth_ff == '0) && (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_valid) begin
         max_len_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ESC_NORMAL;
         depth_ff <= '0;
         code_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         if (fin) begin
            mode_ff  <= ESC_NORMAL;
            depth_ff <= '0;
            code_ff  <= '0;
            count_ff <= '0;
         end else begin
            mode_ff  <= mode_in;
            depth_ff <= depth_in;
            code_ff  <= code_in;
            count_ff <= cnt2[LENGTH_BITS-1:0];
         end
      end
   end

endmodule

FILE: src/pdfsu_queue.sv
// ----------------------------------------------------------------------------
// pdfsu_queue
// Short command queue between the decode front and the output back end.
// ----------------------------------------------------------------------------
module pdfsu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pdfsu_pkg::cmd_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output pdfsu_pkg::cmd_type head
);
   import pdfsu_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]    count_ff;

   assign full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end

endmodule

FILE: src/pdfsu_back.sv
// ----------------------------------------------------------------------------
// pdfsu_back
// Split each command into registered result words, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pdfsu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  pdfsu_pkg::cmd_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pdfsu_pkg::rsp_type rsp_data
);
   import pdfsu_pkg::*;

   logic [2:0] done_ff, done_in;
   logic [2:0] slots, pend, pick;
   logic       rsp_valid_ff, load;
   rsp_type    rsp_data_ff, rsp_in;

   assign slots = empty ? 3'b000 : {head.fin, head.has1, head.has0};
   assign pend  = slots & ~done_ff;
   assign pick  = pend & (~pend + 3'd1);
   assign load  = (!rsp_valid_ff || rsp_ready) && (pend != 3'b000);

   always_comb begin
      rsp_in = '0;
      if (pick[0]) begin
         rsp_in.out_byte = head.data0;
         rsp_in.has_byte = 1'b1;
      end else if (pick[1]) begin
         rsp_in.out_byte = head.data1;
         rsp_in.has_byte = 1'b1;
      end else begin
         rsp_in.string_end      = 1'b1;
         rsp_in.closed_by_paren = head.by_paren;
      end
      done_in = done_ff | pick;
      pop     = load && (done_in == slots);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) done_ff <= pop ? 3'b000 : done_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/sv/tb_pdf_literal_string_unescape_top.sv
// ----------------------------------------------------------------------------
// tb_pdf_literal_string_unescape_top
// Self-checking bench for the PDF literal string unescape block.
// ----------------------------------------------------------------------------
// Raw string bytes go in through a queue-fed driver and decoded words come
// back through a monitor. The monitor keeps its own decoder state, predicts
// the words that each accepted raw byte must produce, and compares every
// returned word field by field. The run covers a directed set of escapes,
// short and truncated octal codes, line continuations and string ends. It
// then runs phases of random strings under several length limits, with one
// phase of deep nesting under a zero limit. Both sides stall at random in most
// phases, and the length limit is only rewritten while the block is quiet.
// ----------------------------------------------------------------------------
module tb_pdf_literal_string_unescape_top;
   import pdfsu_pkg::*;

   typedef enum logic [2:0] {
      MODE_TEXT,
      MODE_BSLASH,
      MODE_OCT1,
      MODE_OCT2,
      MODE_CR
   } scan_mode_type;

   localparam logic [BYTE_W-1:0] CH_DIGIT0 = 8'h30;
   localparam logic [BYTE_W-1:0] CH_DIGIT7 = 8'h37;
   localparam int                DEPTH_TOP = 65535;

   logic               clock;
   logic               reset;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_data;

   req_type            raw_backlog[$];
   rsp_type            pending_decoded[$];
   bit                 req_fire = 1'b0;
   bit                 csr_fire = 1'b0;
   int                 idle_pct = 25;
   int                 mismatch_count = 0;

   scan_mode_type      scan_mode = MODE_TEXT;
   logic [15:0]        nest_depth = '0;
   logic [8:0]         oct_acc = '0;
   logic [14:0]        byte_count = '0;
   logic [CFG_W-1:0]   length_limit = MAX_LEN_RESET;

   pdf_literal_string_unescape_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic req_type raw_word(input logic [BYTE_W-1:0] c, input logic eob);
      req_type w;
      w.in_byte       = c;
      w.end_of_buffer = eob;
      return w;
   endfunction

   function automatic void deliver(input logic [BYTE_W-1:0] b);
      rsp_type r;
      if (byte_count < length_limit) begin
         r.out_byte        = b;
         r.has_byte        = 1'b1;
         r.string_end      = 1'b0;
         r.closed_by_paren = 1'b0;
         pending_decoded   = {pending_decoded, r};
         byte_count++;
      end
   endfunction

   function automatic void decode_word(input req_type w);
      logic [BYTE_W-1:0] c;
      bit                again;
      bit                closed;
      bit                digit;
      rsp_type           fin;
      c      = w.in_byte;
      closed = 1'b0;
      again  = 1'b1;
      while (again) begin
         again = 1'b0;
         digit = (c >= CH_DIGIT0) && (c <= CH_DIGIT7);
         case (scan_mode)
            MODE_BSLASH: begin
               if (digit) begin
                  oct_acc   = {6'd0, c[2:0]};
                  scan_mode = MODE_OCT1;
               end else if (c == CH_CR) begin
                  scan_mode = MODE_CR;
               end else begin
                  scan_mode = MODE_TEXT;
                  case (c)
                     CH_LF:   ;
                     CH_N:    deliver(CH_LF);
                     CH_R:    deliver(CH_CR);
                     CH_T:    deliver(CH_TAB);
                     CH_B:    deliver(CH_BS);
                     CH_F:    deliver(CH_FF);
                     default: deliver(c);
                  endcase
               end
            end
            MODE_OCT1, MODE_OCT2: begin
               if (digit) begin
                  oct_acc = {oct_acc[5:0], c[2:0]};
                  if (scan_mode == MODE_OCT2) begin
                     deliver(oct_acc[7:0]);
                     scan_mode = MODE_TEXT;
                  end else begin
                     scan_mode = MODE_OCT2;
                  end
               end else begin
                  deliver(oct_acc[7:0]);
                  scan_mode = MODE_TEXT;
                  again     = 1'b1;
               end
            end
            MODE_CR: begin
               scan_mode = MODE_TEXT;
               if (c != CH_LF) again = 1'b1;
            end
            default: begin
               scan_mode = MODE_TEXT;
               if (c == CH_RPAREN) begin
                  if (nest_depth == 0) begin
                     closed = 1'b1;
                  end else begin
                     nest_depth--;
                     deliver(c);
                  end
               end else if (c == CH_LPAREN) begin
                  if (nest_depth != DEPTH_TOP) nest_depth++;
                  deliver(c);
               end else if (c == CH_BSLASH) begin
                  scan_mode = MODE_BSLASH;
               end else begin
                  deliver(c);
               end
            end
         endcase
      end
      if (closed || w.end_of_buffer) begin
         fin.out_byte        = '0;
         fin.has_byte        = 1'b0;
         fin.string_end      = 1'b1;
         fin.closed_by_paren = closed;
         pending_decoded     = {pending_decoded, fin};
         scan_mode  = MODE_TEXT;
         nest_depth = '0;
         oct_acc    = '0;
         byte_count = '0;
      end
   endfunction

   // driver: advance to the next word once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (raw_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data  <= raw_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= idle_pct);
   end

   // monitor: check returned words, track the limit, predict new words
   always @(posedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         req_fire = 1'b0;
         csr_fire = 1'b0;
      end else begin
         req_fire = req_valid && req_ready;
         csr_fire = csr_valid && csr_ready;
         if (rsp_valid && rsp_ready) begin
            if (pending_decoded.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: byte %h has %b end %b paren %b",
                           rsp_data.out_byte, rsp_data.has_byte,
                           rsp_data.string_end, rsp_data.closed_by_paren);
            end else begin
               exp_word = pending_decoded.pop_front();
               if (rsp_data.out_byte !== exp_word.out_byte ||
                   rsp_data.has_byte !== exp_word.has_byte ||
                   rsp_data.string_end !== exp_word.string_end ||
                   rsp_data.closed_by_paren !== exp_word.closed_by_paren) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected byte %h has %b end %b paren %b, %s %h %b %b %b",
                              exp_word.out_byte, exp_word.has_byte,
                              exp_word.string_end, exp_word.closed_by_paren, "got",
                              rsp_data.out_byte, rsp_data.has_byte,
                              rsp_data.string_end, rsp_data.closed_by_paren);
               end
            end
         end
         if (csr_fire) length_limit = csr_data;
         if (req_fire) decode_word(req_data);
      end
   end

   task automatic wait_quiet();
      do @(posedge clock);
      while (raw_backlog.size() != 0 || req_valid || pending_decoded.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] limit);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(negedge clock);
      while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   task automatic add_string();
      req_type           s[$];
      int                depth;
      int                n;
      int                kind;
      logic [BYTE_W-1:0] c;
      depth = 0;
      n     = $urandom_range(12, 0);
      if ($urandom_range(99) < 15) begin
         repeat (n + 1)
            s = {s, raw_word(8'($urandom_range(255)), $urandom_range(7) == 0)};
      end else begin
         repeat (n) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
               s = {s, raw_word(8'($urandom_range(255)), 1'b0)};
            end else if (kind < 47) begin
               s = {s, raw_word(CH_LPAREN, 1'b0)};
               depth++;
            end else if (kind < 57 && depth > 0) begin
               s = {s, raw_word(CH_RPAREN, 1'b0)};
               depth--;
            end else begin
               s = {s, raw_word(CH_BSLASH, 1'b0)};
               case ($urandom_range(6))
                  0: begin
                     case ($urandom_range(4))
                        0:       c = CH_N;
                        1:       c = CH_R;
                        2:       c = CH_T;
                        3:       c = CH_B;
                        default: c = CH_F;
                     endcase
                     s = {s, raw_word(c, 1'b0)};
                  end
                  1, 2: repeat ($urandom_range(3, 1))
                     s = {s, raw_word(CH_DIGIT0 + 8'($urandom_range(7)), 1'b0)};
                  3: s = {s, raw_word(CH_CR, 1'b0)};
                  4: begin
                     s = {s, raw_word(CH_CR, 1'b0)};
                     s = {s, raw_word(CH_LF, 1'b0)};
                  end
                  5: s = {s, raw_word(CH_LF, 1'b0)};
                  default: begin
                     case ($urandom_range(3))
                        0:       c = CH_LPAREN;
                        1:       c = CH_RPAREN;
                        2:       c = CH_BSLASH;
                        default: c = 8'($urandom_range(255));
                     endcase
                     s = {s, raw_word(c, 1'b0)};
                  end
               endcase
            end
         end
         if ($urandom_range(1)) begin
            repeat (depth) s = {s, raw_word(CH_RPAREN, 1'b0)};
            s = {s, raw_word(CH_RPAREN, $urandom_range(3) == 0)};
         end else begin
            if (s.size() == 0) s = {s, raw_word(8'($urandom_range(255)), 1'b0)};
            s[s.size()-1].end_of_buffer = 1'b1;
         end
      end
      raw_backlog = {raw_backlog, s};
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] limit, input int idle, input int words);
      wait_quiet();
      write_limit(limit);
      @(posedge clock);
      idle_pct = idle;
      while (raw_backlog.size() < words) add_string();
   endtask

   initial begin
      logic [BYTE_W-1:0] directed[$];
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_data  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_limit(MAX_LEN_RESET);
      @(posedge clock);
      directed = '{8'h00, 8'hFF, CH_LPAREN, CH_RPAREN, CH_BSLASH, CH_N, CH_BSLASH, 8'h71,
                   CH_BSLASH, 8'h37, 8'h37, 8'h37, CH_BSLASH, 8'h35, 8'h61,
                   CH_BSLASH, CH_CR, 8'h7A, CH_BSLASH, CH_CR, CH_LF, CH_BSLASH, CH_LF,
                   CH_BSLASH, 8'h31, 8'h32, CH_RPAREN};
      foreach (directed[i]) raw_backlog = {raw_backlog, raw_word(directed[i], 1'b0)};
      raw_backlog = {raw_backlog, raw_word(CH_BSLASH, 1'b1)};
      raw_backlog = {raw_backlog, raw_word(CH_BSLASH, 1'b0)};
      raw_backlog = {raw_backlog, raw_word(8'h33, 1'b1)};
      raw_backlog = {raw_backlog, raw_word(CH_RPAREN, 1'b1)};

      run_phase(MAX_LEN_RESET, 25, 80);

      // nest deeply under a zero limit, then unwind and close
      wait_quiet();
      write_limit('0);
      @(posedge clock);
      idle_pct = 0;
      repeat (8) raw_backlog = {raw_backlog, raw_word(CH_LPAREN, 1'b0)};
      repeat (9) raw_backlog = {raw_backlog, raw_word(CH_RPAREN, 1'b0)};
      while (raw_backlog.size() < 30) add_string();

      run_phase(15'd5, 25, 50);
      run_phase(CFG_W'($urandom_range(40, 1)), 0, 50);
      run_phase(MAX_LEN_RESET, 25, 50);

      wait_quiet();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
